### rtl/crcfac_pkg.sv
// Shared types, codes and the CRC byte update for the CRC-32 frame append/check block.
package crcfac_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLY      = 2'd1;

  // Direction codes
  localparam logic DIR_APPEND = 1'b0;
  localparam logic DIR_CHECK  = 1'b1;

  // Frame status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_CRC = 2'd1;
  localparam logic [1:0] STAT_SHORT   = 2'd2;

  localparam logic [31:0] POLY_RESET = 32'h04C1_1DB7;

  // Delay line and CRC trailer geometry
  localparam int unsigned DLY_DEPTH = 4;
  localparam int unsigned CRC_BEATS = 4;
  localparam int unsigned BEAT_W    = $clog2(CRC_BEATS + 1);

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One queued job: a first result, optionally followed by four CRC bytes
  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        last;
    logic [1:0]  status;
    logic        has_crc;
    logic [31:0] crc;
  } q_entry_t;

  // Queue fill status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // MSB-first CRC update over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data_in,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {data_in, 24'h0};
    for (int b = 0; b < 8; b++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ poly;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/crcfac_front.sv
// Front end: config registers, CRC update, delay line and job classification.
module crcfac_front import crcfac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_frame_end,
  input  q_stat_t              q_stat,
  output logic                 push,
  output q_entry_t             push_entry
);

  logic        direction_r;
  logic [31:0] poly_r;
  logic [31:0] crc_r, crc_nxt;
  logic [2:0]  bs_r, bs_nxt;
  logic [7:0]  dly_r [DLY_DEPTH];
  logic [7:0]  dly_nxt [DLY_DEPTH];
  logic [31:0] crc_upd;
  logic [1:0]  crc_stat;
  logic        accept;
  logic        want_push;
  logic        clear;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~q_stat.full;
  assign accept    = in_valid & in_ready;
  assign push      = accept & want_push;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_APPEND;
      poly_r      <= POLY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION: direction_r <= cfg_data[0];
        REG_POLY:      poly_r      <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Classify the byte and build the next frame state
  always_comb begin
    crc_upd    = crc_byte(crc_r, in_data_byte, poly_r);
    crc_stat   = (crc_upd == 32'h0) ? STAT_OK : STAT_BAD_CRC;
    crc_nxt    = crc_upd;
    bs_nxt     = bs_r;
    dly_nxt    = dly_r;
    want_push  = 1'b0;
    clear      = 1'b0;
    push_entry = '{data: in_data_byte, present: 1'b1, last: 1'b0, status: STAT_OK,
                   has_crc: 1'b0, crc: crc_upd};
    if (direction_r == DIR_APPEND) begin
      want_push          = 1'b1;
      push_entry.has_crc = in_frame_end;
      clear              = in_frame_end;
    end else if (bs_r[2]) begin
      // Line full: release the oldest byte, shift in the new one
      want_push         = 1'b1;
      push_entry.data   = dly_r[0];
      push_entry.last   = in_frame_end;
      push_entry.status = in_frame_end ? crc_stat : STAT_OK;
      for (int i = 0; i < DLY_DEPTH - 1; i++) begin
        dly_nxt[i] = dly_r[i+1];
      end
      dly_nxt[DLY_DEPTH-1] = in_data_byte;
      clear = in_frame_end;
    end else begin
      // Fill the line
      dly_nxt[bs_r[1:0]] = in_data_byte;
      bs_nxt             = bs_r + 3'd1;
      if (in_frame_end) begin
        want_push          = 1'b1;
        push_entry.data    = 8'h00;
        push_entry.present = 1'b0;
        push_entry.last    = 1'b1;
        push_entry.status  = (bs_r == 3'd3) ? crc_stat : STAT_SHORT;
        clear              = 1'b1;
      end
    end
    if (clear) begin
      crc_nxt = 32'h0;
      bs_nxt  = 3'd0;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 32'h0;
      bs_r  <= 3'd0;
    end else if (accept) begin
      crc_r <= crc_nxt;
      bs_r  <= bs_nxt;
    end
  end

  // Delay line payload
  always_ff @(posedge clk) begin
    if (accept) begin
      dly_r <= dly_nxt;
    end
  end

endmodule

### rtl/crcfac_queue.sv
// Short job queue between the front and back ends.
module crcfac_queue import crcfac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  q_stat
);

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/crcfac_back.sv
// Back end: expands queued jobs into result transfers through an output register.
module crcfac_back import crcfac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_present,
  output logic       out_last,
  output logic [1:0] out_frame_status
);

  logic              out_valid_r;
  logic [7:0]        byte_r, byte_nxt;
  logic              present_r, present_nxt;
  logic              last_r, last_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [BEAT_W-1:0] beat_r;
  logic              load;
  logic              final_beat;

  assign load       = ~q_stat.empty & (~out_valid_r | out_ready);
  assign final_beat = ~head.has_crc | (beat_r == BEAT_W'(CRC_BEATS));
  assign pop        = load & final_beat;

  // Select the result for the current beat of the head job
  always_comb begin
    byte_nxt    = head.data;
    present_nxt = head.present;
    last_nxt    = head.last;
    status_nxt  = head.status;
    case (beat_r)
      BEAT_W'(1): byte_nxt = head.crc[31:24];
      BEAT_W'(2): byte_nxt = head.crc[23:16];
      BEAT_W'(3): byte_nxt = head.crc[15:8];
      BEAT_W'(4): begin
        byte_nxt = head.crc[7:0];
        last_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Beat counter within a job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else if (load) begin
      beat_r <= final_beat ? '0 : beat_r + 1'b1;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_nxt;
      present_r <= present_nxt;
      last_r    <= last_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = byte_r;
  assign out_byte_present = present_r;
  assign out_last         = last_r;
  assign out_frame_status = status_r;

endmodule

### rtl/crc32_frame_append_check_top.sv
// Top level of the CRC-32 frame append/check block.
//
// Input channel: one frame byte per transfer (in_data_byte, in_frame_end on
// the final byte). Result channel: out_byte with out_byte_present, out_last
// and out_frame_status (0 ok, 1 CRC mismatch, 2 frame too short).
// Config channel: cfg_index 0 = direction (0 append, 1 check/strip),
// cfg_index 1 = generator polynomial; other indexes are dropped. cfg_ready
// is always high; write only while the block is idle.
// Path: a result reaches out_valid through the queue entry and then the
// output register (the front classifies into the queue in the accepting
// cycle, the back loads the output register from the stored queue head).
// Throughput: one byte per cycle until the queue fills. The back end emits
// one result per cycle unless stalled; an append frame end yields five
// results, absorbed by the four-entry queue; in_ready drops only when full.
// Check mode holds four bytes in the delay line before the first result.
// Reset (synchronous, active low) sets append mode, polynomial 0x04C11DB7,
// clears the running CRC, fill count, queue and output register.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls until transfers resume.
module crc32_frame_append_check_top import crcfac_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_byte_present,
  output logic                 out_last,
  output logic [1:0]           out_frame_status
);

  q_stat_t  q_stat;
  logic     push;
  logic     pop;
  q_entry_t push_entry;
  q_entry_t head;

  crcfac_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  crcfac_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  crcfac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_present (out_byte_present),
    .out_last         (out_last),
    .out_frame_status (out_frame_status)
  );

endmodule

### rtl/crcfac_checker.sv
// Port-level checker for the CRC-32 frame append/check block, with its bind.
module crcfac_checker import crcfac_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_present,
  input logic       out_last,
  input logic [1:0] out_frame_status
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_byte_present) && $stable(out_frame_status))
    else $error("result changed while stalled");

  // Status-only results close a frame and carry no byte
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_present |-> out_last && out_byte == 8'h00)
    else $error("bad status-only result");

  // Status is only reported on the final result
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_frame_status == STAT_OK)
    else $error("status on non-final result");

  // Too-short frames never carry a byte
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status == STAT_SHORT |-> !out_byte_present)
    else $error("short-frame status with a byte");

endmodule

bind crc32_frame_append_check_top crcfac_checker u_crcfac_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_byte         (out_byte),
  .out_byte_present (out_byte_present),
  .out_last         (out_last),
  .out_frame_status (out_frame_status)
);
